>>> rtl/odo_pkg.sv
// shared types, constants and arctangent table for the odometry block
// no dependencies
`default_nettype none
package odo_pkg;
  localparam int CIRC_W = 12;
  localparam int POS_W = 40;
  localparam int DEG_W = 16;
  localparam int HEAD_W = 16;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam logic [CIRC_W-1:0] CIRC_RST = 12'd200;
  localparam logic [CIRC_W-1:0] BASE_RST = 12'd150;

  // register indexes
  localparam logic CFG_CIRC = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic signed [32:0] KTURN = 33'sd1898792;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [41:0] POS_MAX = 42'sd549755813887;
  localparam logic signed [41:0] POS_MIN = -42'sd549755813888;

  typedef struct packed {
    logic req_type;
    logic signed [DEG_W-1:0] left_degrees;
    logic signed [DEG_W-1:0] right_degrees;
  } odo_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HEAD_W-1:0] heading;
    logic saturated;
  } odo_res_t;

  // arctangent of 2^-i in 1/2^32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/differential_drive_odometry.sv
// dead-reckoning pose tracker for a two-wheel robot, top level
// uses odo_pkg and odo_div
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | odo_req_t: req_type, left/right degrees
// out_    | output    | out_valid/out_stall | odo_res_t: x, y, heading, saturated
// cfg_    | input     | cfg_we              | cfg_idx selects circumference or base
//
// a tick item passes through the heading multiplies, the one-bit-per-cycle heading divider,
// the distance multiply and divide, the cordic iterations and the x and y updates
// zero wheel base skips the heading multiplies and divider; a clear item goes straight to DONE
// synchronous active-low reset clears the pose and loads the default geometry
// the next item is taken while a finished result waits; a stalled output holds the
// block in its last state until the result slot frees
`default_nettype none
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS = odo_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire odo_pkg::odo_req_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output odo_pkg::odo_res_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_idx,
  input  wire logic [odo_pkg::CIRC_W-1:0]        cfg_wdata
);
  localparam int SH = 32 - ANGLE_BITS;          // angle to 32-bit turn shift
  localparam int HDW = ANGLE_BITS + 19;         // heading dividend width
  localparam int DW = HDW;                      // heading divider width
  localparam int NUMW = 51;                     // heading numerator magnitude
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int CW = odo_pkg::CIRC_W;

  // ceil(2^35 / 45), exact floor(m / 45) for m below 2^29
  localparam logic signed [32:0] DC_RECIP = 33'sd763549742;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_HSET = 4'd3;
  localparam logic [3:0] S_HDIV = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_DSET = 4'd6;
  localparam logic [3:0] S_DDIV = 4'd7;
  localparam logic [3:0] S_CINIT = 4'd8;
  localparam logic [3:0] S_CRUN = 4'd9;
  localparam logic [3:0] S_MX   = 4'd10;
  localparam logic [3:0] S_AX   = 4'd11;
  localparam logic [3:0] S_AY   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]               state_r;
  logic [CW-1:0]            circ_r;
  logic [CW-1:0]            base_r;
  logic signed [15:0]       l_r;
  logic signed [15:0]       r_r;
  logic signed [65:0]       p_r;
  logic                     neg_r;
  logic signed [32:0]       dc_r;
  logic signed [32:0]       cx_r;
  logic signed [32:0]       cy_r;
  logic signed [32:0]       cz_r;
  logic                     fold_r;
  logic [SW-1:0]            step_r;
  logic signed [39:0]       pos_x_r;
  logic signed [39:0]       pos_y_r;
  logic [ANGLE_BITS-1:0]    head_r;
  logic                     sat_r;
  logic                     out_valid_r;
  odo_pkg::odo_res_t        out_r;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] product;

  // divider hookup
  logic            div_start;
  logic [DW-1:0]   div_dividend;
  logic [CW-1:0]   div_divisor;
  logic [DW-1:0]   div_quot;
  logic            div_done;

  // misc datapath
  logic [65:0]              p_mag;
  logic [ANGLE_BITS-1:0]    dq;
  logic signed [31:0]       zt;
  logic signed [32:0]       xs;
  logic signed [32:0]       ys;
  logic signed [32:0]       at;
  logic signed [32:0]       cx_nxt;
  logic signed [32:0]       cy_nxt;
  logic signed [32:0]       cz_nxt;
  logic signed [41:0]       acc_pos;
  logic signed [39:0]       clamp_nxt;
  logic                     clamp_hit;
  logic [ANGLE_BITS+15:0]   head_wide;
  logic                     slot_free;

  // distance divide by 720
  logic [23:0]              dc_t;
  logic [28:0]              dc_t45;
  logic [5:0]               dc_rem;
  logic [9:0]               dc_x;
  logic [20:0]              dc_fx;
  logic [32:0]              dc_mag;

  odo_div #(
    .DW(DW),
    .VW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quot    (div_quot),
    .done    (div_done)
  );

  // round to nearest by 2^30, halves away from zero
  function automatic logic signed [41:0] rnd30(input logic signed [65:0] p);
    logic [65:0] m;
    logic [65:0] q;
    m = p[65] ? 66'(-p) : 66'(p);
    q = (m + 66'(1 << 29)) >> 30;
    return p[65] ? -42'(q) : 42'(q);
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = 33'(r_r) - 33'(l_r);
        mul_b = $signed({21'b0, circ_r});
      end
      S_M2: begin
        mul_a = p_r[32:0];
        mul_b = odo_pkg::KTURN;
      end
      S_M3: begin
        mul_a = 33'(r_r) + 33'(l_r);
        mul_b = $signed({21'b0, circ_r});
      end
      S_DSET: begin
        // reciprocal of 45 on the distance magnitude
        mul_a = $signed({4'b0, p_mag[28:0]});
        mul_b = DC_RECIP;
      end
      S_MX: begin
        mul_a = dc_r;
        mul_b = cx_r;
      end
      S_AX: begin
        mul_a = dc_r;
        mul_b = cy_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign product = mul_a * mul_b;

  assign p_mag = p_r[65] ? 66'(-p_r) : 66'(p_r);

  // divider operands: heading step is (|num| + base*2^(SH-1)) / 2^SH / base
  assign div_start = state_r == S_HSET;
  assign div_dividend = DW'((NUMW'(p_mag) + (NUMW'(base_r) << (SH - 1))) >> SH);
  assign div_divisor = base_r;

  assign dq = div_quot[ANGLE_BITS-1:0];
  assign zt = $signed({head_r, {SH{1'b0}}});

  // with m = |s*circ|, (256m + 360) / 720 equals (16m + 22) / 45, taken as
  // 16*floor(m/45) plus floor((16*rem + 22)/45); m sits in dc_r, m*recip in p_r
  assign dc_t = p_r[58:35];
  assign dc_t45 = ({5'b0, dc_t} << 5) + ({5'b0, dc_t} << 3) + ({5'b0, dc_t} << 2)
                + {5'b0, dc_t};
  assign dc_rem = 6'(dc_r[28:0] - dc_t45);
  assign dc_x = {dc_rem, 4'b0} + 10'd22;
  // ceil(2^16 / 45) covers the small remainder step
  assign dc_fx = 21'(dc_x) * 21'd1457;
  assign dc_mag = {5'b0, dc_t, 4'b0} + 33'(dc_fx[20:16]);

  // one cordic micro-rotation
  always_comb begin
    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    at = $signed({3'b0, odo_pkg::atan_turn(5'(step_r))});
    if (!cz_r[32]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + at;
    end
  end

  // position update with clamp, x in AX and y in AY
  always_comb begin
    acc_pos = ((state_r == S_AX) ? 42'(pos_x_r) : 42'(pos_y_r)) + rnd30(p_r);
    clamp_hit = 1'b0;
    if (acc_pos > odo_pkg::POS_MAX) begin
      clamp_nxt = 40'(odo_pkg::POS_MAX);
      clamp_hit = 1'b1;
    end else if (acc_pos < odo_pkg::POS_MIN) begin
      clamp_nxt = 40'(odo_pkg::POS_MIN);
      clamp_hit = 1'b1;
    end else begin
      clamp_nxt = 40'(acc_pos);
    end
  end

  // heading as 16 bits: top bits of the angle, zero padded below
  assign head_wide = {head_r, 16'b0};
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      circ_r <= odo_pkg::CIRC_RST;
      base_r <= odo_pkg::BASE_RST;
      pos_x_r <= '0;
      pos_y_r <= '0;
      head_r <= '0;
      sat_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_r <= '0;
      l_r <= '0;
      r_r <= '0;
      p_r <= '0;
      neg_r <= 1'b0;
      dc_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      fold_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == odo_pkg::CFG_CIRC) begin
          circ_r <= cfg_wdata;
        end else begin
          base_r <= cfg_wdata;
        end
      end
      // result slot: loaded from DONE, emptied when taken
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sat_r <= 1'b0;
            l_r <= in_data.left_degrees;
            r_r <= in_data.right_degrees;
            if (in_data.req_type == odo_pkg::REQ_CLEAR) begin
              pos_x_r <= '0;
              pos_y_r <= '0;
              head_r <= '0;
              state_r <= S_DONE;
            end else if (base_r == '0) begin
              // zero wheel base leaves the heading alone
              state_r <= S_M3;
            end else begin
              state_r <= S_M1;
            end
          end
        end
        S_M1: begin
          p_r <= product;
          state_r <= S_M2;
        end
        S_M2: begin
          p_r <= product;
          state_r <= S_HSET;
        end
        S_HSET: begin
          neg_r <= p_r[65];
          state_r <= S_HDIV;
        end
        S_HDIV: begin
          if (div_done) begin
            head_r <= neg_r ? head_r - dq : head_r + dq;
            state_r <= S_M3;
          end
        end
        S_M3: begin
          p_r <= product;
          state_r <= S_DSET;
        end
        S_DSET: begin
          neg_r <= p_r[65];
          dc_r <= $signed({4'b0, p_mag[28:0]});
          p_r <= product;
          state_r <= S_DDIV;
        end
        S_DDIV: begin
          dc_r <= neg_r ? -$signed(dc_mag) : $signed(dc_mag);
          state_r <= S_CINIT;
        end
        S_CINIT: begin
          // fold into a quarter turn either side of zero
          cx_r <= odo_pkg::CORDIC_GAIN;
          cy_r <= '0;
          step_r <= '0;
          if (zt > 32'sd1073741824) begin
            cz_r <= 33'(zt) - 33'sd2147483648;
            fold_r <= 1'b1;
          end else if (zt < -32'sd1073741824) begin
            cz_r <= 33'(zt) + 33'sd2147483648;
            fold_r <= 1'b1;
          end else begin
            cz_r <= 33'(zt);
            fold_r <= 1'b0;
          end
          state_r <= S_CRUN;
        end
        S_CRUN: begin
          cz_r <= cz_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == SW'(CORDIC_STEPS - 1)) begin
            cx_r <= fold_r ? -cx_nxt : cx_nxt;
            cy_r <= fold_r ? -cy_nxt : cy_nxt;
            state_r <= S_MX;
          end else begin
            cx_r <= cx_nxt;
            cy_r <= cy_nxt;
          end
        end
        S_MX: begin
          p_r <= product;
          state_r <= S_AX;
        end
        S_AX: begin
          pos_x_r <= clamp_nxt;
          sat_r <= sat_r | clamp_hit;
          p_r <= product;
          state_r <= S_AY;
        end
        S_AY: begin
          pos_y_r <= clamp_nxt;
          sat_r <= sat_r | clamp_hit;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_r.x_pos <= pos_x_r;
            out_r.y_pos <= pos_y_r;
            out_r.heading <= head_wide[ANGLE_BITS+15:ANGLE_BITS];
            out_r.saturated <= sat_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

>>> rtl/odo_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none
module odo_div #(
  parameter int DW = 38,
  parameter int VW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quot,
  output logic               done
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [DW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   rem_w;
  logic          ge;

  assign rem_w = {rem_r, q_r[DW-1]};
  assign ge = rem_w >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
      rem_r <= '0;
      q_r <= '0;
      dvs_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(DW);
        rem_r <= '0;
        q_r <= dividend;
        dvs_r <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? VW'(rem_w - {1'b0, dvs_r}) : VW'(rem_w);
        q_r <= {q_r[DW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;
endmodule
`default_nettype wire

>>> rtl/odo_chk.sv
// port-level checks for the odometry block, bound to the top level
// uses odo_pkg
`default_nettype none
module odo_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire odo_pkg::odo_res_t            out_data
);
  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accept");

  // a saturated result shows a clamped coordinate
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (42'(out_data.x_pos) == odo_pkg::POS_MAX) || (42'(out_data.x_pos) == odo_pkg::POS_MIN) ||
      (42'(out_data.y_pos) == odo_pkg::POS_MAX) || (42'(out_data.y_pos) == odo_pkg::POS_MIN))
    else $error("saturated flag without clamped position");

  // reset empties the result slot
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind differential_drive_odometry odo_chk u_odo_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
`default_nettype wire
